FILE: hdl/fsed_pkg.sv
// ----------------------------------------------------------------------------
// Film strip sensor event decoder package
// Shared widths, sensor codes, register indexes and handshake structs.
// ----------------------------------------------------------------------------
package fsed_pkg;

   localparam int POSITION_BITS = 16;
   localparam int COUNT_BITS    = 8;
   localparam int LOCK_FRAMES   = 5;

   localparam int CODE_BITS = 8;
   localparam int THR_BITS  = 8;
   localparam int OUT_POS_BITS = 16;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 8;

   // Common width for comparing a count against a threshold.
   localparam int CMP_BITS = (COUNT_BITS > THR_BITS) ? COUNT_BITS : THR_BITS;

   localparam logic [CODE_BITS-1:0] CODE_FWD_FRAME  = CODE_BITS'(0);
   localparam logic [CODE_BITS-1:0] CODE_BACK_FRAME = CODE_BITS'(1);
   localparam logic [CODE_BITS-1:0] CODE_SCENE_MARK = CODE_BITS'(2);
   localparam logic [CODE_BITS-1:0] CODE_END_MARK   = CODE_BITS'(3);

   localparam logic [CSR_INDEX_BITS-1:0] REG_SCENE_THRESHOLD = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_START_THRESHOLD = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] REG_END_THRESHOLD   = CSR_INDEX_BITS'(2);

   localparam logic [THR_BITS-1:0] SCENE_THRESHOLD_RESET = THR_BITS'(10);
   localparam logic [THR_BITS-1:0] START_THRESHOLD_RESET = THR_BITS'(30);
   localparam logic [THR_BITS-1:0] END_THRESHOLD_RESET   = THR_BITS'(30);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef struct packed {
      logic [THR_BITS-1:0] scene;
      logic [THR_BITS-1:0] start;
      logic [THR_BITS-1:0] finish;
   } thresholds_type;

   typedef struct packed {
      logic                 valid;
      logic [CODE_BITS-1:0] code;
   } stage_type;

endpackage

FILE: hdl/fsed_if.sv
// ----------------------------------------------------------------------------
// Film strip sensor event decoder channels
// Valid/ready interfaces for the code input, the event output and the CSR port.
// ----------------------------------------------------------------------------
interface fsed_req_if;
   logic                           valid;
   logic                           ready;
   logic [fsed_pkg::CODE_BITS-1:0] sensor_code;

   modport source (output valid, output sensor_code, input ready);
   modport sink (input valid, input sensor_code, output ready);
endinterface

interface fsed_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic                                     frame_event;
   logic                                     scene_event;
   logic                                     start_event;
   logic                                     end_event;
   logic signed [fsed_pkg::OUT_POS_BITS-1:0] position_now;

   modport source (output valid, output frame_event, output scene_event,
                   output start_event, output end_event, output position_now,
                   input ready);
   modport sink (input valid, input frame_event, input scene_event,
                 input start_event, input end_event, input position_now,
                 output ready);
endinterface

interface fsed_csr_if;
   logic                                valid;
   logic                                ready;
   logic [fsed_pkg::CSR_INDEX_BITS-1:0] index;
   logic [fsed_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/fsed_csr.sv
// ----------------------------------------------------------------------------
// Threshold registers
// Holds the scene, start and end thresholds written over the CSR port.
// ----------------------------------------------------------------------------
module fsed_csr (
   input  logic                     clock,
   input  logic                     reset,
   fsed_csr_if.sink                 csr_chan,
   output fsed_pkg::thresholds_type thresholds
);

   fsed_pkg::thresholds_type thr_ff;
   fsed_pkg::thresholds_type thr_in;
   logic                     write_en;

   assign csr_chan.ready = 1'b1;
   assign write_en       = csr_chan.valid;
   assign thresholds     = thr_ff;

   always_comb begin
      thr_in = thr_ff;
      if (write_en) begin
         unique case (csr_chan.index)
            fsed_pkg::REG_SCENE_THRESHOLD: thr_in.scene  = fsed_pkg::THR_BITS'(csr_chan.data);
            fsed_pkg::REG_START_THRESHOLD: thr_in.start  = fsed_pkg::THR_BITS'(csr_chan.data);
            fsed_pkg::REG_END_THRESHOLD:   thr_in.finish = fsed_pkg::THR_BITS'(csr_chan.data);
            default: thr_in = thr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff.scene  <= fsed_pkg::SCENE_THRESHOLD_RESET;
         thr_ff.start  <= fsed_pkg::START_THRESHOLD_RESET;
         thr_ff.finish <= fsed_pkg::END_THRESHOLD_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

endmodule

FILE: hdl/fsed_in_stage.sv
// ----------------------------------------------------------------------------
// Input register
// Captures one sensor code per transaction and hands it to the tracker.
// ----------------------------------------------------------------------------
module fsed_in_stage (
   input  logic                clock,
   input  logic                reset,
   fsed_req_if.sink            req_chan,
   input  logic                take,
   output fsed_pkg::stage_type stage
);

   logic                           valid_ff;
   logic                           valid_in;
   logic [fsed_pkg::CODE_BITS-1:0] code_ff;
   logic                           load;

   // The register can refill in the same cycle its content moves on.
   assign req_chan.ready = !valid_ff || take;
   assign load           = req_chan.valid && req_chan.ready;
   assign stage.valid    = valid_ff;
   assign stage.code     = code_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_ff <= req_chan.sensor_code;
      end
   end

endmodule

FILE: hdl/fsed_tracker.sv
// ----------------------------------------------------------------------------
// Film position and sensor count tracker
// Updates direction, position and saturating counts for one code and
// registers the resulting events for the output channel.
// ----------------------------------------------------------------------------
module fsed_tracker (
   input  logic                     clock,
   input  logic                     reset,
   input  fsed_pkg::stage_type      stage,
   input  fsed_pkg::thresholds_type thresholds,
   output logic                     take,
   fsed_rsp_if.source               rsp_chan
);

   localparam int PB = fsed_pkg::POSITION_BITS;
   localparam int CB = fsed_pkg::COUNT_BITS;
   localparam int MB = fsed_pkg::CMP_BITS;

   logic          fwd_ff, fwd_in;
   logic [PB-1:0] pos_ff, pos_in;
   logic [PB-1:0] last_scene_ff, last_scene_in;
   logic [CB-1:0] scene_cnt_ff, scene_cnt_in;
   logic [CB-1:0] start_cnt_ff, start_cnt_in;
   logic [CB-1:0] end_cnt_ff, end_cnt_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          frame_ev_ff, frame_ev_in;
   logic          scene_ev_ff, scene_ev_in;
   logic          start_ev_ff, start_ev_in;
   logic          end_ev_ff, end_ev_in;

   logic [PB-1:0] pos_up;
   logic [PB-1:0] lock_pos;
   logic [CB-1:0] scene_cnt_t;
   logic [CB-1:0] start_cnt_t;
   logic [CB-1:0] end_cnt_t;

   // The result register frees up when it is empty or being read this cycle.
   assign take = stage.valid && (!rsp_valid_ff || rsp_chan.ready);

   assign pos_up   = pos_ff + PB'(1);
   assign lock_pos = last_scene_ff + PB'(fsed_pkg::LOCK_FRAMES);

   always_comb begin
      fwd_in        = fwd_ff;
      pos_in        = pos_ff;
      last_scene_in = last_scene_ff;
      scene_cnt_in  = scene_cnt_ff;
      start_cnt_in  = start_cnt_ff;
      end_cnt_in    = end_cnt_ff;
      frame_ev_in   = 1'b0;
      scene_ev_in   = 1'b0;
      start_ev_in   = 1'b0;
      end_ev_in     = 1'b0;
      scene_cnt_t   = scene_cnt_ff;
      start_cnt_t   = start_cnt_ff;
      end_cnt_t     = end_cnt_ff;

      if (fwd_ff && scene_cnt_ff != fsed_pkg::COUNT_MAX) begin
         scene_cnt_t = scene_cnt_ff + CB'(1);
      end
      if (fwd_ff && end_cnt_ff != fsed_pkg::COUNT_MAX) begin
         end_cnt_t = end_cnt_ff + CB'(1);
      end
      if (!fwd_ff && start_cnt_ff != fsed_pkg::COUNT_MAX) begin
         start_cnt_t = start_cnt_ff + CB'(1);
      end

      unique case (stage.code)
         fsed_pkg::CODE_FWD_FRAME: begin
            fwd_in      = 1'b1;
            frame_ev_in = 1'b1;
            pos_in      = pos_up;
            if (pos_up == lock_pos) begin
               scene_cnt_in = '0;
            end
         end
         fsed_pkg::CODE_BACK_FRAME: begin
            fwd_in       = 1'b0;
            pos_in       = pos_ff - PB'(1);
            scene_cnt_in = '0;
         end
         fsed_pkg::CODE_SCENE_MARK: begin
            scene_cnt_in = scene_cnt_t;
            if (MB'(scene_cnt_t) == MB'(thresholds.scene)) begin
               scene_ev_in   = 1'b1;
               last_scene_in = pos_ff;
            end
         end
         fsed_pkg::CODE_END_MARK: begin
            // The end threshold wins when both would be reached.
            if (MB'(end_cnt_t) >= MB'(thresholds.finish)) begin
               end_ev_in    = 1'b1;
               end_cnt_in   = '0;
               start_cnt_in = '0;
            end else if (MB'(start_cnt_t) >= MB'(thresholds.start)) begin
               start_ev_in  = 1'b1;
               end_cnt_in   = '0;
               start_cnt_in = '0;
            end else begin
               end_cnt_in   = end_cnt_t;
               start_cnt_in = start_cnt_t;
            end
         end
         default: begin
            fwd_in = fwd_ff;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff        <= 1'b0;
         pos_ff        <= '0;
         last_scene_ff <= '0;
         scene_cnt_ff  <= '0;
         start_cnt_ff  <= '0;
         end_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            fwd_ff        <= fwd_in;
            pos_ff        <= pos_in;
            last_scene_ff <= last_scene_in;
            scene_cnt_ff  <= scene_cnt_in;
            start_cnt_ff  <= start_cnt_in;
            end_cnt_ff    <= end_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         frame_ev_ff <= frame_ev_in;
         scene_ev_ff <= scene_ev_in;
         start_ev_ff <= start_ev_in;
         end_ev_ff   <= end_ev_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.frame_event  = frame_ev_ff;
   assign rsp_chan.scene_event  = scene_ev_ff;
   assign rsp_chan.start_event  = start_ev_ff;
   assign rsp_chan.end_event    = end_ev_ff;
   // The position register only changes together with the result register.
   assign rsp_chan.position_now = fsed_pkg::OUT_POS_BITS'(pos_ff);

endmodule

FILE: hdl/film_strip_sensor_event_decoder_unit.sv
// ----------------------------------------------------------------------------
// Film strip sensor event decoder
// Turns a stream of sensor code bytes into frame, scene, start and end events
// and a running frame position.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one sensor code per transaction; rsp_chan returns exactly
//   one result per code, in order: four event flags and the position after
//   that code. csr_chan writes the scene (index 0), start (index 1) and end
//   (index 2) thresholds; other indexes are ignored. csr_chan is always ready
//   and should only be written while no codes are in flight.
//   An accepted code passes through the input register and then through the
//   state update into the result register before its result shows on rsp_chan.
//   Throughput is one code per cycle while rsp_chan is ready, bounded by the
//   single state update step.
//   When the receiver holds off, the result register keeps its transaction
//   and the input register still takes one more code; after that req_chan
//   ready drops until rsp_chan is read.
//   Reset clears both stages, the position, direction and counts, and loads
//   the thresholds with 10, 30 and 30. No clearing pass is needed.
// ----------------------------------------------------------------------------
module film_strip_sensor_event_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   fsed_req_if.sink   req_chan,
   fsed_rsp_if.source rsp_chan,
   fsed_csr_if.sink   csr_chan
);

   fsed_pkg::thresholds_type thresholds;
   fsed_pkg::stage_type      stage;
   logic                     take;

   fsed_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_chan   (csr_chan),
      .thresholds (thresholds)
   );

   fsed_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (take),
      .stage    (stage)
   );

   fsed_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .stage      (stage),
      .thresholds (thresholds),
      .take       (take),
      .rsp_chan   (rsp_chan)
   );

endmodule
